### src/eihc_pkg.sv
`timescale 1ns / 1ps

package eihc_pkg;

    // Header layout, in byte positions from the start of the frame
    localparam int unsigned HDR_BYTES   = 34;
    localparam int unsigned DEST_END    = 6;
    localparam int unsigned SOURCE_END  = 12;
    localparam int unsigned TYPE_END    = 14;
    localparam int unsigned LEN_HI_POS  = 16;
    localparam int unsigned LEN_LO_POS  = 17;
    localparam int unsigned ID_HI_POS   = 18;
    localparam int unsigned ID_LO_POS   = 19;
    localparam int unsigned SUM_HI_POS  = 24;
    localparam int unsigned SUM_LO_POS  = 25;

    localparam int unsigned POS_W       = 6;
    localparam int unsigned RUN_SUM_W   = 20;

    // Default depth of the queue between front and back
    localparam int unsigned EIHC_FIFO_DEPTH = 4;

    // EtherType values
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_RARP = 16'h8035;

    typedef enum logic [2:0] {
        CLS_IPV4  = 3'd0,
        CLS_IPV6  = 3'd1,
        CLS_ARP   = 3'd2,
        CLS_RARP  = 3'd3,
        CLS_OTHER = 3'd4
    } t_type_class;

    // One captured frame, as handed from front to back
    typedef struct packed {
        logic [47:0]          dest_mac;
        logic [47:0]          source_mac;
        logic [15:0]          ether_type;
        logic [15:0]          ip_ident;
        logic [15:0]          ip_total_length;
        logic [15:0]          sum_received;
        logic [RUN_SUM_W-1:0] run_sum;
        logic                 complete;
    } t_frame_rec;

endpackage

### src/eihc_front.sv
`timescale 1ns / 1ps

module eihc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_frame_byte,
    input  logic                i_frame_end,
    input  logic                i_full,
    output logic                o_stall,
    output logic                o_push,
    output eihc_pkg::t_frame_rec o_rec
);
    import eihc_pkg::*;

    logic [POS_W-1:0]     r_pos, n_pos;
    logic [47:0]          r_dest, n_dest;
    logic [47:0]          r_source, n_source;
    logic [15:0]          r_type, n_type;
    logic [15:0]          r_ident, n_ident;
    logic [15:0]          r_len, n_len;
    logic [15:0]          r_rx, n_rx;
    logic [RUN_SUM_W-1:0] r_sum, n_sum;
    logic [7:0]           r_pend, n_pend;
    logic                 take;

    // Stall the link only when the queue has no room
    assign o_stall = i_full;
    assign take    = i_valid && !i_full;
    assign o_push  = take && i_frame_end;

    // Shift the incoming byte into the field that owns its position
    always_comb begin
        n_pos    = r_pos;
        n_dest   = r_dest;
        n_source = r_source;
        n_type   = r_type;
        n_ident  = r_ident;
        n_len    = r_len;
        n_rx     = r_rx;
        n_sum    = r_sum;
        n_pend   = r_pend;
        if (r_pos < POS_W'(HDR_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
            if (r_pos < POS_W'(DEST_END)) begin
                n_dest = {r_dest[39:0], i_frame_byte};
            end else if (r_pos < POS_W'(SOURCE_END)) begin
                n_source = {r_source[39:0], i_frame_byte};
            end else if (r_pos < POS_W'(TYPE_END)) begin
                n_type = {r_type[7:0], i_frame_byte};
            end else begin
                if (r_pos == POS_W'(LEN_HI_POS) || r_pos == POS_W'(LEN_LO_POS)) begin
                    n_len = {r_len[7:0], i_frame_byte};
                end else if (r_pos == POS_W'(ID_HI_POS) || r_pos == POS_W'(ID_LO_POS)) begin
                    n_ident = {r_ident[7:0], i_frame_byte};
                end else if (r_pos == POS_W'(SUM_HI_POS)
                             || r_pos == POS_W'(SUM_LO_POS)) begin
                    n_rx = {r_rx[7:0], i_frame_byte};
                end
                // IP header starts on an even position: even bytes are word highs
                if (!r_pos[0]) begin
                    n_pend = i_frame_byte;
                end else if (r_pos != POS_W'(SUM_LO_POS)) begin
                    n_sum = r_sum + {{(RUN_SUM_W-16){1'b0}}, r_pend, i_frame_byte};
                end
            end
        end
    end

    // Hand the finished frame to the queue, including this beat
    always_comb begin
        o_rec.dest_mac        = n_dest;
        o_rec.source_mac      = n_source;
        o_rec.ether_type      = n_type;
        o_rec.ip_ident        = n_ident;
        o_rec.ip_total_length = n_len;
        o_rec.sum_received    = n_rx;
        o_rec.run_sum         = n_sum;
        o_rec.complete        = (n_pos >= POS_W'(HDR_BYTES));
    end

    // Advance on each beat; clear at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_frame_end)) begin
            r_pos    <= '0;
            r_dest   <= '0;
            r_source <= '0;
            r_type   <= '0;
            r_ident  <= '0;
            r_len    <= '0;
            r_rx     <= '0;
            r_sum    <= '0;
            r_pend   <= '0;
        end else if (take) begin
            r_pos    <= n_pos;
            r_dest   <= n_dest;
            r_source <= n_source;
            r_type   <= n_type;
            r_ident  <= n_ident;
            r_len    <= n_len;
            r_rx     <= n_rx;
            r_sum    <= n_sum;
            r_pend   <= n_pend;
        end
    end

`ifndef SYNTHESIS
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(HDR_BYTES))
        else $error("byte position ran past the header");
`endif

endmodule

### src/eihc_fifo.sv
`timescale 1ns / 1ps

module eihc_fifo #(
    parameter int unsigned DEPTH = eihc_pkg::EIHC_FIFO_DEPTH  // 2 or more
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  eihc_pkg::t_frame_rec i_rec,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output eihc_pkg::t_frame_rec o_rec
);
    import eihc_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_frame_rec       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rd];

    // Write the entry at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

### src/eihc_back.sv
`timescale 1ns / 1ps

module eihc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  eihc_pkg::t_frame_rec i_rec,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [47:0]          o_dest_mac,
    output logic [47:0]          o_source_mac,
    output logic [15:0]          o_ether_type,
    output logic [2:0]           o_type_class,
    output logic [15:0]          o_ip_ident,
    output logic [15:0]          o_ip_total_length,
    output logic [15:0]          o_sum_received,
    output logic [15:0]          o_sum_computed,
    output logic                 o_sum_match,
    output logic                 o_header_complete
);
    import eihc_pkg::*;

    t_type_class cls;
    logic        ipv4;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] computed;
    logic [15:0] rx;
    logic        r_valid;

    // Classify the EtherType
    always_comb begin
        case (i_rec.ether_type)
            ETYPE_IPV4: cls = CLS_IPV4;
            ETYPE_IPV6: cls = CLS_IPV6;
            ETYPE_ARP:  cls = CLS_ARP;
            ETYPE_RARP: cls = CLS_RARP;
            default:    cls = CLS_OTHER;
        endcase
    end

    // Fold the running sum twice and complement; non-IPv4 frames report zero sums
    always_comb begin
        ipv4     = (cls == CLS_IPV4);
        fold1    = {1'b0, i_rec.run_sum[15:0]}
                   + {13'b0, i_rec.run_sum[RUN_SUM_W-1:16]};
        fold2    = fold1[15:0] + {15'b0, fold1[16]};
        computed = ipv4 ? ~fold2 : 16'h0000;
        rx       = ipv4 ? i_rec.sum_received : 16'h0000;
    end

    // Take a record whenever the output register is free or draining
    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_dest_mac        <= i_rec.dest_mac;
            o_source_mac      <= i_rec.source_mac;
            o_ether_type      <= i_rec.ether_type;
            o_type_class      <= cls;
            o_ip_ident        <= i_rec.ip_ident;
            o_ip_total_length <= i_rec.ip_total_length;
            o_sum_received    <= rx;
            o_sum_computed    <= computed;
            o_sum_match       <= ipv4 && i_rec.complete && (rx == computed);
            o_header_complete <= i_rec.complete;
        end
    end

`ifndef SYNTHESIS
    a_match_needs_ipv4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sum_match) |->
            (o_type_class == CLS_IPV4 && o_header_complete))
        else $error("checksum match on a non-IPv4 or short frame");
    a_sum_zero_non_ipv4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_type_class != CLS_IPV4) |->
            (o_sum_computed == 16'h0000 && o_sum_received == 16'h0000))
        else $error("checksum reported for a non-IPv4 frame");
`endif

endmodule

### src/ethernet_ipv4_header_checker.sv
`timescale 1ns / 1ps
// Ethernet / IPv4 header checker.
// Input channel: one frame byte per beat (i_frame_byte), with i_frame_end high
// on the last byte. A beat is taken when i_valid is high and o_stall is low.
// Output channel: one result beat per frame (MACs, EtherType and its class,
// IPv4 length, ident, received and recomputed header checksum, match flag,
// header-complete flag), taken when o_valid is high and i_stall is low.
// Throughput: one byte per cycle, sustained while o_stall is low; back-to-back
// frames of any length, down to one byte, run at that rate. The header fields and the
// running checksum are updated as each byte streams in.
// A finished frame is written into the queue when its last byte is taken, and moves
// into the output register once that register is free or draining.
// Finished frames wait in a FIFO_DEPTH-entry queue ahead of the output
// register; o_stall rises only when that queue is full, which can happen
// only after the receiver has held i_stall high.
// Reset clears the byte position, all captured fields, the queue and the
// output valid; the first byte after reset opens a new frame.
// Bytes after the 34th of a frame are ignored until its end mark.

module ethernet_ipv4_header_checker #(
    parameter int unsigned FIFO_DEPTH = eihc_pkg::EIHC_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [47:0] o_dest_mac,
    output logic [47:0] o_source_mac,
    output logic [15:0] o_ether_type,
    output logic [2:0]  o_type_class,
    output logic [15:0] o_ip_ident,
    output logic [15:0] o_ip_total_length,
    output logic [15:0] o_sum_received,
    output logic [15:0] o_sum_computed,
    output logic        o_sum_match,
    output logic        o_header_complete
);
    import eihc_pkg::*;

    t_frame_rec push_rec;
    t_frame_rec head_rec;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;

    eihc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_frame_byte (i_frame_byte),
        .i_frame_end  (i_frame_end),
        .i_full       (full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_rec        (push_rec)
    );

    eihc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_rec   (head_rec)
    );

    eihc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (empty),
        .i_rec             (head_rec),
        .o_pop             (pop),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_dest_mac        (o_dest_mac),
        .o_source_mac      (o_source_mac),
        .o_ether_type      (o_ether_type),
        .o_type_class      (o_type_class),
        .o_ip_ident        (o_ip_ident),
        .o_ip_total_length (o_ip_total_length),
        .o_sum_received    (o_sum_received),
        .o_sum_computed    (o_sum_computed),
        .o_sum_match       (o_sum_match),
        .o_header_complete (o_header_complete)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import eihc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_BYTES   = 520;
    localparam int unsigned RANDOM_FRAMES  = 16;
    localparam int unsigned QUIET_AFTER    = 440;
    localparam int unsigned REPORT_LIMIT   = 10;

    // One header report, as the output channel carries it
    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] ether_type;
        t_type_class type_class;
        logic [15:0] ip_ident;
        logic [15:0] ip_total_length;
        logic [15:0] sum_received;
        logic [15:0] sum_computed;
        logic        sum_match;
        logic        header_complete;
    } t_hdr_report;

    // Directed frame: bytes are fill + step * index, EtherType laid over bytes 12..13
    typedef struct packed {
        logic [6:0]  nbytes;
        logic [7:0]  fill;
        logic [7:0]  step;
        logic [15:0] ether_type;
        logic        fix_sum;
        logic        typed;
        t_hdr_report want;
    } t_frame_row;

    typedef struct packed {
        logic        typed;
        t_hdr_report want;
    } t_frame_note;

    localparam int unsigned N_ROWS = 13;
    localparam t_frame_row DIRECTED [N_ROWS] = '{
        '{7'd1, 8'hFF, 8'h00, 16'h0000, 1'b0, 1'b1,
          '{48'hFF, 48'h0, 16'h0000, CLS_OTHER, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0}},
        '{7'd34, 8'h00, 8'h00, ETYPE_IPV4, 1'b0, 1'b1,
          '{48'h0, 48'h0, ETYPE_IPV4, CLS_IPV4, 16'h0, 16'h0, 16'h0, 16'hFFFF, 1'b0, 1'b1}},
        '{7'd34, 8'hFF, 8'h00, 16'hFFFF, 1'b0, 1'b1,
          '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, CLS_OTHER, 16'hFFFF,
            16'hFFFF, 16'h0, 16'h0, 1'b0, 1'b1}},
        '{7'd34, 8'h45, 8'h13, ETYPE_IPV4, 1'b1, 1'b0, '0},
        '{7'd34, 8'h45, 8'h13, ETYPE_IPV4, 1'b0, 1'b0, '0},
        '{7'd20, 8'h11, 8'h07, ETYPE_IPV4, 1'b0, 1'b0, '0},
        '{7'd13, 8'hA5, 8'h03, ETYPE_IPV6, 1'b0, 1'b0, '0},
        '{7'd40, 8'h3C, 8'h1D, ETYPE_IPV6, 1'b0, 1'b0, '0},
        '{7'd34, 8'h5A, 8'h0B, ETYPE_ARP,  1'b0, 1'b0, '0},
        '{7'd34, 8'hC3, 8'h11, ETYPE_RARP, 1'b1, 1'b0, '0},
        '{7'd64, 8'h01, 8'h25, ETYPE_IPV4, 1'b1, 1'b0, '0},
        '{7'd26, 8'h80, 8'h05, ETYPE_IPV4, 1'b1, 1'b0, '0},
        '{7'd14, 8'h7E, 8'h09, ETYPE_IPV4, 1'b0, 1'b0, '0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_frame_byte;
    logic        i_frame_end;
    logic        o_valid;
    logic        i_stall;
    logic [47:0] o_dest_mac;
    logic [47:0] o_source_mac;
    logic [15:0] o_ether_type;
    logic [2:0]  o_type_class;
    logic [15:0] o_ip_ident;
    logic [15:0] o_ip_total_length;
    logic [15:0] o_sum_received;
    logic [15:0] o_sum_computed;
    logic        o_sum_match;
    logic        o_header_complete;

    ethernet_ipv4_header_checker i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_frame_byte      (i_frame_byte),
        .i_frame_end       (i_frame_end),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_dest_mac        (o_dest_mac),
        .o_source_mac      (o_source_mac),
        .o_ether_type      (o_ether_type),
        .o_type_class      (o_type_class),
        .o_ip_ident        (o_ip_ident),
        .o_ip_total_length (o_ip_total_length),
        .o_sum_received    (o_sum_received),
        .o_sum_computed    (o_sum_computed),
        .o_sum_match       (o_sum_match),
        .o_header_complete (o_header_complete)
    );

    // Header tracker state, mirrors what the block captures per frame
    int unsigned hdr_pos;
    logic [47:0] cap_dest;
    logic [47:0] cap_source;
    logic [15:0] cap_type;
    logic [15:0] cap_ident;
    logic [15:0] cap_length;
    logic [15:0] cap_rx_sum;
    logic [19:0] sum_acc;
    logic [7:0]  sum_hi;

    t_hdr_report pending_reports[$];
    t_frame_note frame_notes[$];
    logic [7:0]  frame_buf[$];

    int unsigned header_faults;
    int unsigned idle_cycles;
    int unsigned gap_pct;
    int unsigned stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic string show_report(input t_hdr_report r);
        return $sformatf({"dst=%012h src=%012h type=%04h cls=%0d id=%04h len=%04h ",
                          "rx=%04h calc=%04h match=%0b full=%0b"},
                         r.dest_mac, r.source_mac, r.ether_type, r.type_class, r.ip_ident,
                         r.ip_total_length, r.sum_received, r.sum_computed, r.sum_match,
                         r.header_complete);
    endfunction

    task automatic clear_capture();
        hdr_pos    = 0;
        cap_dest   = '0;
        cap_source = '0;
        cap_type   = '0;
        cap_ident  = '0;
        cap_length = '0;
        cap_rx_sum = '0;
        sum_acc    = '0;
        sum_hi     = '0;
    endtask

    // Advance the header tracker by one accepted byte; queue a report at frame end
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        t_hdr_report rep;
        t_frame_note note;
        logic [16:0] fold;
        if (hdr_pos < HDR_BYTES) begin
            if (hdr_pos < DEST_END) begin
                cap_dest = {cap_dest[39:0], b};
            end else if (hdr_pos < SOURCE_END) begin
                cap_source = {cap_source[39:0], b};
            end else if (hdr_pos < TYPE_END) begin
                cap_type = {cap_type[7:0], b};
            end else begin
                if (hdr_pos == LEN_HI_POS || hdr_pos == LEN_LO_POS) begin
                    cap_length = {cap_length[7:0], b};
                end else if (hdr_pos == ID_HI_POS || hdr_pos == ID_LO_POS) begin
                    cap_ident = {cap_ident[7:0], b};
                end else if (hdr_pos == SUM_HI_POS || hdr_pos == SUM_LO_POS) begin
                    cap_rx_sum = {cap_rx_sum[7:0], b};
                end
                // Even offsets into the IP header open a word, odd ones close it
                if (((hdr_pos - TYPE_END) % 2) == 0) begin
                    sum_hi = b;
                end else if (hdr_pos != SUM_LO_POS) begin
                    sum_acc = sum_acc + {4'h0, sum_hi, b};
                end
            end
            hdr_pos++;
        end
        if (last) begin
            case (cap_type)
                ETYPE_IPV4: rep.type_class = CLS_IPV4;
                ETYPE_IPV6: rep.type_class = CLS_IPV6;
                ETYPE_ARP:  rep.type_class = CLS_ARP;
                ETYPE_RARP: rep.type_class = CLS_RARP;
                default:    rep.type_class = CLS_OTHER;
            endcase
            fold = {13'h0, sum_acc[19:16]} + {1'b0, sum_acc[15:0]};
            fold = {1'b0, fold[15:0]} + {16'h0, fold[16]};
            rep.dest_mac        = cap_dest;
            rep.source_mac      = cap_source;
            rep.ether_type      = cap_type;
            rep.ip_ident        = cap_ident;
            rep.ip_total_length = cap_length;
            rep.header_complete = (hdr_pos >= HDR_BYTES);
            if (rep.type_class == CLS_IPV4) begin
                rep.sum_received = cap_rx_sum;
                rep.sum_computed = ~fold[15:0];
            end else begin
                rep.sum_received = '0;
                rep.sum_computed = '0;
            end
            rep.sum_match = (rep.type_class == CLS_IPV4) && rep.header_complete &&
                            (rep.sum_received == rep.sum_computed);
            // Typed-in expectations from the directed table take precedence
            note = frame_notes.pop_front();
            pending_reports.push_back(note.typed ? note.want : rep);
            clear_capture();
        end
    endtask

    // Check result beats, track input beats, and run the watchdog
    always @(posedge i_clk) begin
        t_hdr_report seen;
        t_hdr_report want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                seen = '{o_dest_mac, o_source_mac, o_ether_type, t_type_class'(o_type_class),
                         o_ip_ident, o_ip_total_length, o_sum_received, o_sum_computed,
                         o_sum_match, o_header_complete};
                if (pending_reports.size() == 0) begin
                    header_faults++;
                    if (header_faults <= REPORT_LIMIT)
                        $display("unexpected report: %s", show_report(seen));
                end else begin
                    want = pending_reports.pop_front();
                    if (seen !== want) begin
                        header_faults++;
                        if (header_faults <= REPORT_LIMIT) begin
                            $display("report mismatch, expected: %s", show_report(want));
                            $display("                 actual:   %s", show_report(seen));
                        end
                    end
                end
            end
            if (i_valid && !o_stall)
                absorb_byte(i_frame_byte, i_frame_end);
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Receiver: stall in random bursts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Checksum that makes the header in frame_buf valid
    function automatic logic [15:0] good_header_sum();
        logic [19:0] acc;
        logic [16:0] fold;
        logic [7:0]  hi;
        logic [7:0]  lo;
        acc = '0;
        for (int p = TYPE_END; p < HDR_BYTES; p += 2) begin
            if (p != SUM_HI_POS) begin
                hi  = (p < frame_buf.size()) ? frame_buf[p] : 8'h00;
                lo  = (p + 1 < frame_buf.size()) ? frame_buf[p + 1] : 8'h00;
                acc = acc + {4'h0, hi, lo};
            end
        end
        fold = {13'h0, acc[19:16]} + {1'b0, acc[15:0]};
        fold = {1'b0, fold[15:0]} + {16'h0, fold[16]};
        return ~fold[15:0];
    endfunction

    task automatic build_frame(input int unsigned n, input logic [15:0] etype,
                               input logic [7:0] fill, input logic [7:0] step,
                               input bit rand_fill, input bit fix_sum);
        logic [15:0] s;
        frame_buf.delete();
        for (int i = 0; i < n; i++) begin
            if (rand_fill)
                frame_buf.push_back(8'($urandom_range(0, 255)));
            else
                frame_buf.push_back(fill + step * i[7:0]);
        end
        if (n > 12) frame_buf[12] = etype[15:8];
        if (n > 13) frame_buf[13] = etype[7:0];
        if (fix_sum && n > SUM_LO_POS) begin
            s = good_header_sum();
            frame_buf[SUM_HI_POS] = s[15:8];
            frame_buf[SUM_LO_POS] = s[7:0];
        end
    endtask

    // Present one beat, with an optional gap ahead of it, and hold it until taken
    task automatic send_beat(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_frame_byte <= b;
        i_frame_end  <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_frame(input t_frame_note note);
        frame_notes.push_back(note);
        for (int i = 0; i < frame_buf.size(); i++)
            send_beat(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Drop valid after the last taken beat, then wait for every report
    task automatic drain_reports();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sent_bytes;
        int unsigned frames;
        int unsigned n;
        int unsigned pick;
        logic [15:0] etype;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_frame_byte  = '0;
        i_frame_end   = 1'b0;
        header_faults = 0;
        idle_cycles   = 0;
        gap_pct       = 10;
        stall_pct     = 10;
        clear_capture();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames
        for (int r = 0; r < N_ROWS; r++) begin
            build_frame(DIRECTED[r].nbytes, DIRECTED[r].ether_type, DIRECTED[r].fill,
                        DIRECTED[r].step, 1'b0, DIRECTED[r].fix_sum);
            send_frame('{DIRECTED[r].typed, DIRECTED[r].want});
        end
        drain_reports();

        // Random frames, mostly well-formed headers with random content
        sent_bytes = 0;
        frames     = 0;
        while (sent_bytes < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
            if (sent_bytes > QUIET_AFTER) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (frames % 8 == 0) begin
                pick      = $urandom_range(0, 2);
                gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 5 : 25;
                pick      = $urandom_range(0, 2);
                stall_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 30;
            end
            if (frames % 37 == 36) drain_reports();

            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3, 4: etype = ETYPE_IPV4;
                5:             etype = ETYPE_IPV6;
                6:             etype = ETYPE_ARP;
                7:             etype = ETYPE_RARP;
                8:             etype = 16'($urandom_range(0, 16'hFFFF));
                default:       etype = ETYPE_IPV4 ^ (16'h1 << $urandom_range(0, 15));
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1:          n = $urandom_range(1, 3);
                2, 3:          n = $urandom_range(4, 33);
                4, 5, 6, 7:    n = $urandom_range(34, 40);
                default:       n = $urandom_range(41, 64);
            endcase
            build_frame(n, etype, 8'h00, 8'h00, 1'b1, $urandom_range(0, 3) != 0);
            send_frame('{1'b0, '0});
            sent_bytes += n;
            frames++;
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        drain_reports();
        repeat (10) @(posedge i_clk);
        if (header_faults == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
